@@ src/float_text_format_classifier_core_defines.svh @@
`ifndef FLOAT_TEXT_FORMAT_CLASSIFIER_CORE_DEFINES_SVH
`define FLOAT_TEXT_FORMAT_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FTFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ftfc_pkg.sv @@
package ftfc_pkg;

   localparam int POS_W = 7;
   localparam logic [POS_W-1:0] MAX_CHARS = 7'd64;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   localparam logic [3:0] SIG_CODE_MAX = 4'd15;
   localparam logic [1:0] EXP_CODE_MAX = 2'd3;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_UNSUPPORTED = 2'd1,
      ERR_MALFORMED   = 2'd2
   } err_code_type;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_PLUS  = 2'd1,
      SIGN_MINUS = 2'd2
   } exp_sign_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      err_code_type error_code;
      logic         scientific;
      logic         upper_e;
      exp_sign_type exponent_sign;
      logic [1:0]   exponent_digits_code;
      logic [3:0]   significant_digits_code;
   } rsp_payload_type;

endpackage

@@ src/ftfc_track.sv @@
module ftfc_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  ftfc_pkg::req_payload_type item,
   output ftfc_pkg::rsp_payload_type result
);
   import ftfc_pkg::*;

   logic [POS_W-1:0] cp_ff, cp_in;
   logic             dot_seen_ff, dot_seen_in;
   logic [POS_W-1:0] dot_pos_ff, dot_pos_in;
   logic             exp_seen_ff, exp_seen_in;
   logic [POS_W-1:0] exp_pos_ff, exp_pos_in;
   logic [POS_W-1:0] fsp_ff, fsp_in;
   logic             x_upper_ff, x_upper_in;
   logic             x_plus_ff, x_plus_in;
   logic             x_minus_ff, x_minus_in;
   logic             x_valid_ff, x_valid_in;
   logic             lz_nondig_ff, lz_nondig_in;
   logic             lz_zero_ff, lz_zero_in;
   logic             lz_next_ff, lz_next_in;
   logic [POS_W-1:0] ecount_ff, ecount_in;
   logic             too_long_ff, too_long_in;

   // Scan one character.
   always_comb begin
      logic [7:0]       c;
      logic             dig;
      logic             letter;
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] lead;
      logic [POS_W-1:0] q;

      c      = item.char_code;
      dig    = (c >= CH_ZERO) && (c <= CH_NINE);
      letter = (c == CH_UPPER_E) || (c == CH_LOWER_E);
      p      = cp_ff;
      q      = p - exp_pos_ff;
      lead   = '0;

      cp_in        = cp_ff;
      dot_seen_in  = dot_seen_ff;
      dot_pos_in   = dot_pos_ff;
      exp_seen_in  = exp_seen_ff;
      exp_pos_in   = exp_pos_ff;
      fsp_in       = fsp_ff;
      x_upper_in   = x_upper_ff;
      x_plus_in    = x_plus_ff;
      x_minus_in   = x_minus_ff;
      x_valid_in   = x_valid_ff;
      lz_nondig_in = lz_nondig_ff;
      lz_zero_in   = lz_zero_ff;
      lz_next_in   = lz_next_ff;
      ecount_in    = ecount_ff;
      too_long_in  = too_long_ff;

      if (step_en) begin
         if (p >= MAX_CHARS) begin
            too_long_in = 1'b1;
         end else begin
            if ((p == '0) && !dig) lz_nondig_in = 1'b1;
            lead = {{(POS_W-1){1'b0}}, lz_nondig_in};
            if ((p == lead) && (c == CH_ZERO)) lz_zero_in = 1'b1;
            if ((p == lead + POS_W'(1)) && dig) lz_next_in = 1'b1;

            if (exp_seen_ff) begin
               ecount_in = ecount_ff + POS_W'(1);
               if (q == POS_W'(1)) begin
                  if (dig) x_valid_in = 1'b1;
                  else if (c == CH_PLUS) x_plus_in = 1'b1;
                  else if (c == CH_MINUS) x_minus_in = 1'b1;
               end else if ((q == POS_W'(2)) && dig && (x_plus_ff || x_minus_ff)) begin
                  x_valid_in = 1'b1;
               end
            end else if (letter) begin
               exp_seen_in = 1'b1;
               exp_pos_in  = p;
               if (c == CH_UPPER_E) x_upper_in = 1'b1;
            end else if (dot_seen_ff && (fsp_ff == '0) && (c != CH_ZERO)) begin
               fsp_in = p;
            end

            if ((c == CH_DOT) && !dot_seen_ff) begin
               dot_seen_in = 1'b1;
               dot_pos_in  = p;
            end
            cp_in = p + POS_W'(1);
         end
      end
   end

   // Classify from the state that includes this character.
   always_comb begin
      logic [POS_W-1:0] first;
      logic [POS_W-1:0] end_pos;
      logic [POS_W-1:0] diff;
      logic             dec;
      logic [POS_W-1:0] sig_m1;
      logic             has_sign;
      logic [POS_W-1:0] ed_m1;

      first   = {{(POS_W-1){1'b0}}, lz_nondig_in};
      if (lz_zero_in && dot_seen_in && (fsp_in != '0)) first = fsp_in;
      end_pos = exp_seen_in ? exp_pos_in : cp_in;
      diff    = end_pos - first;
      dec     = dot_seen_in && (first < dot_pos_in);
      sig_m1  = diff - POS_W'(1) - {{(POS_W-1){1'b0}}, dec};
      has_sign = x_plus_in || x_minus_in;
      if (ecount_in <= {{(POS_W-1){1'b0}}, has_sign}) ed_m1 = '0;
      else ed_m1 = ecount_in - {{(POS_W-1){1'b0}}, has_sign} - POS_W'(1);

      result = '0;
      if (too_long_in) begin
         result.error_code = ERR_MALFORMED;
      end else if (exp_seen_in && !x_valid_in) begin
         result.error_code = ERR_UNSUPPORTED;
      end else if (lz_zero_in && lz_next_in) begin
         result.error_code = ERR_UNSUPPORTED;
      end else if ((first >= end_pos) || ((diff == POS_W'(1)) && dec)) begin
         result.error_code = ERR_MALFORMED;
      end else begin
         result.error_code = ERR_NONE;
         result.significant_digits_code =
            (sig_m1 > POS_W'(SIG_CODE_MAX)) ? SIG_CODE_MAX : sig_m1[3:0];
         if (exp_seen_in) begin
            result.scientific = 1'b1;
            result.upper_e    = x_upper_in;
            if (x_plus_in) result.exponent_sign = SIGN_PLUS;
            else if (x_minus_in) result.exponent_sign = SIGN_MINUS;
            else result.exponent_sign = SIGN_NONE;
            result.exponent_digits_code =
               (ed_m1 > POS_W'(EXP_CODE_MAX)) ? EXP_CODE_MAX : ed_m1[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last_char)) begin
         cp_ff        <= '0;
         dot_seen_ff  <= 1'b0;
         dot_pos_ff   <= '0;
         exp_seen_ff  <= 1'b0;
         exp_pos_ff   <= '0;
         fsp_ff       <= '0;
         x_upper_ff   <= 1'b0;
         x_plus_ff    <= 1'b0;
         x_minus_ff   <= 1'b0;
         x_valid_ff   <= 1'b0;
         lz_nondig_ff <= 1'b0;
         lz_zero_ff   <= 1'b0;
         lz_next_ff   <= 1'b0;
         ecount_ff    <= '0;
         too_long_ff  <= 1'b0;
      end else begin
         cp_ff        <= cp_in;
         dot_seen_ff  <= dot_seen_in;
         dot_pos_ff   <= dot_pos_in;
         exp_seen_ff  <= exp_seen_in;
         exp_pos_ff   <= exp_pos_in;
         fsp_ff       <= fsp_in;
         x_upper_ff   <= x_upper_in;
         x_plus_ff    <= x_plus_in;
         x_minus_ff   <= x_minus_in;
         x_valid_ff   <= x_valid_in;
         lz_nondig_ff <= lz_nondig_in;
         lz_zero_ff   <= lz_zero_in;
         lz_next_ff   <= lz_next_in;
         ecount_ff    <= ecount_in;
         too_long_ff  <= too_long_in;
      end
   end

endmodule

@@ src/float_text_format_classifier_core.sv @@
// Channel | Dir | Handshake            | Beat
// req     | in  | req_valid/req_ready  | req_payload: one character, last flag
// rsp     | out | rsp_valid/rsp_ready  | rsp_payload: format of one whole text
//
// One character per cycle, sustained while no stalled result holds a last character;
// each beat waits in the input register while the scan logic updates the per-text
// state. The result register loads as the last character leaves the input register.
// Reset clears the scan state and both valid flags; state also clears after
// each last character. A stalled result blocks only a waiting last character.
module float_text_format_classifier_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ftfc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ftfc_pkg::rsp_payload_type rsp_payload
);
   import ftfc_pkg::*;
   `include "float_text_format_classifier_core_defines.svh"

   logic            in_valid_ff;
   req_payload_type in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type scan_result;
   logic            advance;

   // A non-last character never needs the result register.
   assign advance   = in_valid_ff &&
                      (!in_item_ff.last_char || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ftfc_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (scan_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_item_ff.last_char) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) in_item_ff <= req_payload;
      if (advance && in_item_ff.last_char) rsp_payload_ff <= scan_result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FTFC_ASSERT_NOW(a_err_clears_fields, clock, reset,
      rsp_valid_ff && (rsp_payload_ff.error_code != ERR_NONE),
      !rsp_payload_ff.scientific && (rsp_payload_ff.significant_digits_code == 4'd0),
      "error result carries nonzero fields")
   `FTFC_ASSERT_NOW(a_plain_no_exp, clock, reset,
      rsp_valid_ff && !rsp_payload_ff.scientific,
      !rsp_payload_ff.upper_e && (rsp_payload_ff.exponent_sign == SIGN_NONE) &&
      (rsp_payload_ff.exponent_digits_code == 2'd0),
      "exponent fields set without exponent")
   `FTFC_ASSERT_NEXT(a_last_held, clock, reset,
      in_valid_ff && in_item_ff.last_char && rsp_valid_ff && !rsp_ready,
      in_valid_ff && in_item_ff.last_char,
      "last character dropped while result stalled")
   `FTFC_ASSERT_NEXT(a_last_gives_rsp, clock, reset,
      advance && in_item_ff.last_char,
      rsp_valid_ff,
      "last character produced no result")

endmodule
